[sv/glpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpf_pkg
// Shared constants and types of the grid local peak finder.
// ----------------------------------------------------------------------------
package glpf_pkg;

   // default sizes
   localparam int DEF_MAX_DIM    = 32;
   localparam int DEF_PIXEL_BITS = 16;

   // register file layout
   localparam int CFG_BITS      = 6;
   localparam int CSR_ADDR_BITS = 4;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_ROWS = CSR_ADDR_BITS'(0);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_COLS = CSR_ADDR_BITS'(1);

   // neighbor availability and forwarding of one request, set at acceptance
   typedef struct packed {
      logic has_up;     // row above exists, so the request decides a pixel
      logic has_left;   // decided pixel has a left neighbor in the frame
      logic has_right;  // decided pixel has a right neighbor in the frame
      logic fwd_a;      // centre read hits the write of the same cycle
      logic fwd_b;      // right read hits the write of the same cycle
   } glpf_pos_type;

endpackage

[sv/glpf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpf_ram
// Generic RAM, one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module glpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

[sv/glpf_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpf_eval
// Compare stage: takes line buffer read data, decides the pixel above the
// request, writes the request pixel back and holds the result register.
// ----------------------------------------------------------------------------
module glpf_eval #(
   parameter int MAX_DIM    = glpf_pkg::DEF_MAX_DIM,
   parameter int PIXEL_BITS = glpf_pkg::DEF_PIXEL_BITS,
   localparam int COL_W     = $clog2(MAX_DIM),
   localparam int ROW_W     = $clog2(MAX_DIM + 1),
   localparam int AW        = COL_W + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_accept,
   output logic                         in_ready,
   input  glpf_pkg::glpf_pos_type       in_pos,
   input  logic [ROW_W-1:0]             in_row,
   input  logic [COL_W-1:0]             in_col,
   input  logic signed [PIXEL_BITS-1:0] in_down,
   input  logic [PIXEL_BITS:0]          rd_a_data,
   input  logic [PIXEL_BITS:0]          rd_b_data,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic [PIXEL_BITS:0]          wr_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [COL_W-1:0]             out_row,
   output logic [COL_W-1:0]             out_col
);

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   glpf_pkg::glpf_pos_type       s1_pos_ff;
   logic [ROW_W-1:0]             s1_row_ff;
   logic [COL_W-1:0]             s1_col_ff;
   logic signed [PIXEL_BITS-1:0] s1_down_ff;
   logic [PIXEL_BITS:0]          fwd_data_ff;
   logic signed [PIXEL_BITS-1:0] left_ff;
   logic                         out_valid_ff;
   logic [COL_W-1:0]             out_row_ff;
   logic [COL_W-1:0]             out_col_ff;

   logic                         s1_go;
   logic [PIXEL_BITS:0]          centre_word;
   logic [PIXEL_BITS:0]          right_word;
   logic signed [PIXEL_BITS-1:0] centre_v;
   logic signed [PIXEL_BITS-1:0] left_v;
   logic signed [PIXEL_BITS-1:0] right_v;
   logic                         centre_ge_up;
   logic                         is_peak;
   logic                         down_ge_up;
   logic [ROW_W-1:0]             row_above;

   // stage advances whenever the result register is free or being drained
   assign s1_go    = !out_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || s1_go;

   // read data with forwarding of the write that shared the read edge
   assign centre_word  = s1_pos_ff.fwd_a ? fwd_data_ff : rd_a_data;
   assign right_word   = s1_pos_ff.fwd_b ? fwd_data_ff : rd_b_data;
   assign centre_v     = $signed(centre_word[PIXEL_BITS-1:0]);
   assign centre_ge_up = centre_word[PIXEL_BITS];
   assign right_v      = s1_pos_ff.has_right ? $signed(right_word[PIXEL_BITS-1:0]) : '0;
   assign left_v       = s1_pos_ff.has_left ? left_ff : '0;

   // peak decision for the pixel one row up
   assign is_peak = s1_pos_ff.has_up && centre_ge_up && (centre_v >= s1_down_ff) &&
                    (centre_v >= left_v) && (centre_v >= right_v);

   // write back the request pixel with its own compare against the row above
   assign down_ge_up = s1_pos_ff.has_up ? (s1_down_ff >= centre_v) : !s1_down_ff[PIXEL_BITS-1];
   assign wr_en      = s1_valid_ff && s1_go;
   assign wr_addr    = {s1_row_ff[0], s1_col_ff};
   assign wr_data    = {down_ge_up, s1_down_ff};

   assign row_above = s1_row_ff - ROW_W'(1);

   // stage valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (in_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            out_valid_ff <= s1_valid_ff && is_peak;
         end
      end
   end

   // stage payload, captured at acceptance
   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_pos_ff   <= in_pos;
         s1_row_ff   <= in_row;
         s1_col_ff   <= in_col;
         s1_down_ff  <= in_down;
         fwd_data_ff <= wr_data;
      end
   end

   // left neighbor is the centre of the previous request in the row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_ff <= centre_v;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_go && s1_valid_ff) begin
         out_row_ff <= row_above[COL_W-1:0];
         out_col_ff <= s1_col_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_row   = out_row_ff;
   assign out_col   = out_col_ff;

   // a request is only taken when the stage can pass its occupant on
   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      in_accept |-> in_ready)
      else $error("request accepted while compare stage is blocked");

   // a first-row request never yields a result
   a_first_row_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_go && !s1_pos_ff.has_up) |=> !out_valid_ff)
      else $error("result produced for a first-row request");

endmodule

[sv/grid_local_peak_finder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_peak_finder_core
// Streaming 4-neighbor local maximum detector over a raster frame of signed
// pixels, with a two-row line buffer RAM.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata: pixel_value, tuser: req_type
//  rsp      out  rsp_tvalid/tready    tdata: peak_row, peak_col
//  csr      in   csr_valid/ready      csr_addr: register, csr_wdata: value
//
//  One request per clock unless the result port stalls; a result moves from
//  the compare stage register, which holds its request, to the output register.
//  The line buffer RAM (2 * MAX_DIM words) serves centre and right reads in
//  one access; the left neighbor and the compare against the row above ride
//  in registers and in a flag stored with each word.
//  Reset clears counters and handshake state and sets both dimensions to 1;
//  the RAM is not cleared, and no clearing pass is needed.
//  A stalled result port holds the compare stage; requests stall only then.
// ----------------------------------------------------------------------------
module grid_local_peak_finder_core #(
   parameter int MAX_DIM    = glpf_pkg::DEF_MAX_DIM,
   parameter int PIXEL_BITS = glpf_pkg::DEF_PIXEL_BITS,
   localparam int COL_W     = $clog2(MAX_DIM),
   localparam int ROW_W     = $clog2(MAX_DIM + 1),
   localparam int REQ_W     = ((PIXEL_BITS + 7) / 8) * 8,
   localparam int RSP_W     = ((2 * COL_W + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_W-1:0]                   req_tdata,  // pixel_value
   input  logic [0:0]                         req_tuser,  // req_type
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_W-1:0]                   rsp_tdata,  // peak_row, peak_col
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [glpf_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [glpf_pkg::CFG_BITS-1:0]      csr_wdata
);

   localparam int AW    = COL_W + 1;
   localparam int CMP_W = (ROW_W > glpf_pkg::CFG_BITS) ? ROW_W : glpf_pkg::CFG_BITS;

   logic [ROW_W-1:0]             rows_ff;
   logic [ROW_W-1:0]             rows_in;
   logic [ROW_W-1:0]             cols_ff;
   logic [ROW_W-1:0]             cols_in;
   logic [ROW_W-1:0]             row_count_ff;
   logic [ROW_W-1:0]             row_count_in;
   logic [COL_W-1:0]             col_count_ff;
   logic [COL_W-1:0]             col_count_in;

   logic                         csr_write;
   logic                         csr_hit;
   logic [CMP_W-1:0]             csr_ext;
   logic [ROW_W-1:0]             dim_clamped;

   logic                         req_accept;
   logic                         pad_zero;
   logic [ROW_W-1:0]             col_plus;
   logic                         row_end;
   logic signed [PIXEL_BITS-1:0] down_v;
   glpf_pkg::glpf_pos_type       pos;

   logic [AW-1:0]                rd_a_addr;
   logic [AW-1:0]                rd_b_addr;
   logic [PIXEL_BITS:0]          rd_a_data;
   logic [PIXEL_BITS:0]          rd_b_data;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [PIXEL_BITS:0]          wr_data;
   logic [COL_W-1:0]             peak_row;
   logic [COL_W-1:0]             peak_col;

   // register writes: out-of-range sizes clamp to 1..MAX_DIM
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_ext   = CMP_W'(csr_wdata);

   always_comb begin
      if (csr_ext == '0) begin
         dim_clamped = ROW_W'(1);
      end else if (csr_ext > CMP_W'(MAX_DIM)) begin
         dim_clamped = ROW_W'(MAX_DIM);
      end else begin
         dim_clamped = ROW_W'(csr_ext);
      end
   end

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      csr_hit = 1'b0;
      case (csr_addr)
         glpf_pkg::CSR_FRAME_ROWS: begin
            rows_in = dim_clamped;
            csr_hit = 1'b1;
         end
         glpf_pkg::CSR_FRAME_COLS: begin
            cols_in = dim_clamped;
            csr_hit = 1'b1;
         end
         default: begin
            csr_hit = 1'b0;
         end
      endcase
   end

   // raster position of the incoming request
   assign req_accept = req_tvalid && req_tready;
   assign pad_zero   = req_tuser[0] || (row_count_ff >= rows_ff);
   assign down_v     = pad_zero ? '0 : $signed(req_tdata[PIXEL_BITS-1:0]);
   assign col_plus   = ROW_W'(col_count_ff) + ROW_W'(1);
   assign row_end    = col_plus >= cols_ff;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_write && csr_hit) begin
         row_count_in = '0;
         col_count_in = '0;
      end else if (req_accept) begin
         if (row_end) begin
            col_count_in = '0;
            row_count_in = (row_count_ff >= rows_ff) ? '0 : row_count_ff + ROW_W'(1);
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROW_W'(1);
         cols_ff      <= ROW_W'(1);
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else begin
         if (csr_write) begin
            rows_ff <= rows_in;
            cols_ff <= cols_in;
         end
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // line buffer reads: row above at this column and the next one
   assign rd_a_addr = {~row_count_ff[0], col_count_ff};
   assign rd_b_addr = {~row_count_ff[0], col_count_ff + COL_W'(1)};

   assign pos.has_up    = row_count_ff != '0;
   assign pos.has_left  = col_count_ff != '0;
   assign pos.has_right = !row_end;
   assign pos.fwd_a     = wr_en && (wr_addr == rd_a_addr);
   assign pos.fwd_b     = wr_en && (wr_addr == rd_b_addr);

   glpf_ram #(
      .WIDTH (PIXEL_BITS + 1),
      .DEPTH (2 * MAX_DIM)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (req_accept),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   glpf_eval #(
      .MAX_DIM    (MAX_DIM),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_ready  (req_tready),
      .in_pos    (pos),
      .in_row    (row_count_ff),
      .in_col    (col_count_ff),
      .in_down   (down_v),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_row   (peak_row),
      .out_col   (peak_col)
   );

   assign rsp_tdata = RSP_W'({peak_col, peak_row});

   // column counter stays inside the frame width
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      ROW_W'(col_count_ff) < cols_ff)
      else $error("column counter beyond frame width");

   // row counter reaches at most the pad row
   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= rows_ff)
      else $error("row counter beyond pad row");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid local peak finder core. A short directed
// table covers the value extremes, pad and pixel misuse, and the register
// clamping, restart and unused-index cases. Random frames of varied size and
// content follow. Every accepted request goes through a cycle-free predictor,
// and each result is checked in order against the queue of predicted peaks.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_DIM   = 32;
   localparam int ITEM_GOAL = 1500;
   localparam int DRAIN     = 8;
   localparam int SQUEEZE   = 200;
   localparam int AB        = glpf_pkg::CSR_ADDR_BITS;
   localparam int CB        = glpf_pkg::CFG_BITS;

   localparam logic [AB-1:0] CSR_SPARE_LO = AB'(2);
   localparam logic [AB-1:0] CSR_SPARE    = AB'(9);

   typedef enum logic {REQ_PIXEL = 1'b0, REQ_PAD = 1'b1} req_kind_type;
   typedef enum int {EXP_MODEL, EXP_NONE, EXP_PEAK} exp_kind_type;
   typedef enum int {STEP_CFG, STEP_REQ} step_kind_type;

   typedef struct packed {
      logic [4:0] col;
      logic [4:0] row;
   } peak_type;

   typedef struct {
      step_kind_type             kind;
      logic [AB-1:0]             addr;
      logic [CB-1:0]             wdata;
      req_kind_type              typ;
      logic signed [15:0]        pix;
      exp_kind_type              mode;
      peak_type                  peak;
   } dir_row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata  = '0;  // pixel_value
   logic [0:0]                req_tuser  = '0;  // req_type
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [15:0]               rsp_tdata;        // peak_row, peak_col
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [AB-1:0]             csr_addr   = '0;
   logic [CB-1:0]             csr_wdata  = '0;

   grid_local_peak_finder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: two rows of pixels, position counters, raw registers
   int            line_mem [2][MAX_DIM];
   int            next_row = 0;
   int            next_col = 0;
   logic [CB-1:0] rows_reg = CB'(1);
   logic [CB-1:0] cols_reg = CB'(1);

   peak_type     peak_q [$];
   dir_row_type  dir_tab [$];
   int           sent_cnt     = 0;
   int           mismatch_cnt = 0;
   bit           tx_burst     = 1'b0;
   bit           hold_rsp     = 1'b0;
   bit           squeeze_go   = 1'b0;

   // out-of-range dimensions clamp to 1..MAX_DIM
   function automatic int dim_of(logic [CB-1:0] raw);
      if (raw == 0) return 1;
      if (int'(raw) > MAX_DIM) return MAX_DIM;
      return int'(raw);
   endfunction

   // register write: known index stores and restarts the frame
   task automatic apply_csr(input logic [AB-1:0] addr,
                            input logic [CB-1:0] data);
      if (addr == glpf_pkg::CSR_FRAME_ROWS || addr == glpf_pkg::CSR_FRAME_COLS) begin
         if (addr == glpf_pkg::CSR_FRAME_ROWS) rows_reg = data;
         else cols_reg = data;
         next_row = 0;
         next_col = 0;
      end
   endtask

   // one request: decide the pixel above, store this one, advance position
   task automatic advance_finder(input req_kind_type typ, input logic signed [15:0] pix,
                                 output bit hit, output peak_type pk);
      int rows, cols, r, c, mid, centre, n_val, s_val, w_val, e_val;
      rows = dim_of(rows_reg);
      cols = dim_of(cols_reg);
      r = next_row;
      c = next_col;
      s_val = (typ == REQ_PAD || r >= rows) ? 0 : int'(pix);
      if (c >= cols) c = cols - 1;
      if (r > rows) r = rows;
      hit = 1'b0;
      pk = '0;
      if (r >= 1) begin
         mid    = (r - 1) % 2;
         centre = line_mem[mid][c];
         n_val  = (r >= 2) ? line_mem[r % 2][c] : 0;
         w_val  = (c > 0) ? line_mem[mid][c - 1] : 0;
         e_val  = (c + 1 < cols) ? line_mem[mid][c + 1] : 0;
         if (centre >= n_val && centre >= s_val && centre >= w_val && centre >= e_val) begin
            hit    = 1'b1;
            pk.row = 5'(r - 1);
            pk.col = 5'(c);
         end
      end
      line_mem[r % 2][c] = s_val;
      if (c + 1 >= cols) begin
         next_col = 0;
         next_row = (r >= rows) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
         next_row = r;
      end
   endtask

   // sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      if (hold_rsp || tx_burst) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [15:0] pick_pixel(int style);
      case (style)
         0: return 16'($urandom_range(0, 65535));
         1: return 16'($urandom_range(0, 6) - 3);
         default: begin
            case ($urandom_range(0, 5))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return 16'sh0000;
               3: return 16'shffff;
               4: return 16'sh0001;
               default: return 16'($urandom_range(0, 65535));
            endcase
         end
      endcase
   endfunction

   // offer one request, predict on acceptance
   task automatic send_req(input req_kind_type typ, input logic signed [15:0] pix,
                           input exp_kind_type mode, input peak_type typed);
      int       gap;
      bit       hit;
      peak_type pk;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= typ;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_cnt++;
      advance_finder(typ, pix, hit, pk);
      if (mode == EXP_PEAK) peak_q.push_back(typed);
      else if (mode == EXP_MODEL && hit) peak_q.push_back(pk);
   endtask

   // drop valid, wait for all peaks, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (peak_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(input logic [AB-1:0] addr,
                            input logic [CB-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(addr, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one frame plus its pad row, optionally noisy or cut short
   task automatic send_frame(input int rows, input int cols, input int shape, input int style);
      int           total, cut, r;
      req_kind_type typ;
      total = (rows + 1) * cols;
      cut   = (shape == 2) ? $urandom_range(1, total - 1) : total;
      for (int k = 0; k < cut; k++) begin
         r   = k / cols;
         typ = (r == rows) ? REQ_PAD : REQ_PIXEL;
         if (shape == 1 && $urandom_range(0, 6) == 0)
            typ = (typ == REQ_PAD) ? REQ_PIXEL : REQ_PAD;
         send_req(typ, pick_pixel(style), EXP_MODEL, '0);
      end
   endtask

   task automatic add_cfg(input logic [AB-1:0] addr, input logic [CB-1:0] data);
      dir_row_type e;
      e = '{STEP_CFG, addr, data, REQ_PIXEL, '0, EXP_MODEL, '0};
      dir_tab.push_back(e);
   endtask

   task automatic add_req(input req_kind_type typ, input logic signed [15:0] pix,
                          input exp_kind_type mode, input int row, input int col);
      dir_row_type e;
      e = '{STEP_REQ, '0, '0, typ, pix, mode, '{col: 5'(col), row: 5'(row)}};
      dir_tab.push_back(e);
   endtask

   // result side ready: random stalls, ready bursts, one long hold-off
   int rx_stall = 0;
   int rx_span  = 0;
   bit rx_burst = 1'b0;
   always @(negedge clock) begin : rsp_ready_gen
      int roll;
      if (rx_span == 0) begin
         rx_burst = ($urandom_range(0, 3) == 0);
         rx_span  = $urandom_range(50, 300);
      end else begin
         rx_span--;
      end
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         rsp_tready <= 1'b0;
      end else if (rx_burst) begin
         rsp_tready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            rx_stall = $urandom_range(8, 40);
            rsp_tready <= 1'b0;
         end else if (roll < 20) begin
            rx_stall = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long hold-off so the block backs up into the request side
   initial begin : squeeze
      wait (squeeze_go);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (SQUEEZE) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // compare each result with the oldest predicted peak
   always @(posedge clock) begin : peak_check
      peak_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row = rsp_tdata[4:0];
         got.col = rsp_tdata[9:5];
         if (peak_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected peak: row %0d col %0d", got.row, got.col);
         end else begin
            want = peak_q.pop_front();
            if (got.row !== want.row || got.col !== want.col) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("peak mismatch: expected row %0d col %0d, got row %0d col %0d",
                           want.row, want.col, got.row, got.col);
            end
         end
      end
   end

   // watchdog
   initial begin : watchdog
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      int rv, cv, nfr, shape, style;
      for (int h = 0; h < 2; h++)
         for (int c = 0; c < MAX_DIM; c++)
            line_mem[h][c] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 1x1 after reset: negative pixel loses to zero border, positive wins
      add_req(REQ_PIXEL, -16'sd5, EXP_NONE, 0, 0);
      add_req(REQ_PAD, 16'sh5a5a, EXP_NONE, 0, 0);
      add_req(REQ_PIXEL, 16'sd7, EXP_NONE, 0, 0);
      add_req(REQ_PAD, 16'sh5a5a, EXP_PEAK, 0, 0);
      // 2x3 with extremes, a pad inside the frame, a pixel in the pad row
      add_cfg(glpf_pkg::CSR_FRAME_ROWS, 6'd2);
      add_cfg(glpf_pkg::CSR_FRAME_COLS, 6'd3);
      add_req(REQ_PIXEL, 16'sh7fff, EXP_NONE, 0, 0);
      add_req(REQ_PIXEL, 16'sh8000, EXP_NONE, 0, 0);
      add_req(REQ_PIXEL, 16'sh0000, EXP_NONE, 0, 0);
      add_req(REQ_PAD, 16'sh1234, EXP_PEAK, 0, 0);
      add_req(REQ_PIXEL, -16'sd1, EXP_NONE, 0, 0);
      add_req(REQ_PIXEL, 16'sh7fff, EXP_NONE, 0, 0);
      add_req(REQ_PIXEL, 16'sd100, EXP_NONE, 0, 0);
      add_req(REQ_PAD, 16'sh0000, EXP_NONE, 0, 0);
      add_req(REQ_PAD, 16'sh0000, EXP_PEAK, 1, 2);
      // restart by rewrite, unused index mid-frame leaves position alone, ties
      add_cfg(glpf_pkg::CSR_FRAME_ROWS, 6'd2);
      add_req(REQ_PIXEL, 16'sd3, EXP_MODEL, 0, 0);
      add_req(REQ_PIXEL, 16'sd3, EXP_MODEL, 0, 0);
      add_req(REQ_PIXEL, -16'sd2, EXP_MODEL, 0, 0);
      add_cfg(CSR_SPARE, 6'd63);
      add_req(REQ_PIXEL, 16'sd3, EXP_MODEL, 0, 0);
      add_req(REQ_PIXEL, 16'sd1, EXP_MODEL, 0, 0);
      add_req(REQ_PIXEL, -16'sd2, EXP_MODEL, 0, 0);
      add_req(REQ_PAD, 16'sh0000, EXP_MODEL, 0, 0);
      add_req(REQ_PAD, 16'shffff, EXP_MODEL, 0, 0);
      add_req(REQ_PAD, 16'sh0000, EXP_MODEL, 0, 0);
      // zero dimensions act as 1
      add_cfg(glpf_pkg::CSR_FRAME_ROWS, 6'd0);
      add_cfg(glpf_pkg::CSR_FRAME_COLS, 6'd0);
      add_req(REQ_PIXEL, 16'sh8000, EXP_MODEL, 0, 0);
      add_req(REQ_PAD, 16'sh0000, EXP_NONE, 0, 0);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == STEP_CFG)
            write_csr(dir_tab[i].addr, dir_tab[i].wdata);
         else
            send_req(dir_tab[i].typ, dir_tab[i].pix, dir_tab[i].mode, dir_tab[i].peak);
      end

      // random phases: new dimensions, then a few frames
      for (int phase = 0; sent_cnt < ITEM_GOAL; phase++) begin
         case (phase)
            0: begin rv = 32; cv = 2;  end
            1: begin rv = 2;  cv = 32; end
            2: begin rv = 63; cv = 1;  end
            3: begin rv = 1;  cv = 63; end
            4: begin rv = 33; cv = 0;  end
            5: begin rv = 0;  cv = 40; end
            default: begin
               if ($urandom_range(0, 99) < 85) begin
                  rv = $urandom_range(1, 6);
                  cv = $urandom_range(1, 6);
               end else if ($urandom_range(0, 1) == 0) begin
                  rv = $urandom_range(0, 63);
                  cv = $urandom_range(1, 4);
               end else begin
                  rv = $urandom_range(1, 4);
                  cv = $urandom_range(0, 63);
               end
            end
         endcase
         if ($urandom_range(0, 1) == 0) begin
            write_csr(glpf_pkg::CSR_FRAME_ROWS, CB'(rv));
            write_csr(glpf_pkg::CSR_FRAME_COLS, CB'(cv));
         end else begin
            write_csr(glpf_pkg::CSR_FRAME_COLS, CB'(cv));
            write_csr(glpf_pkg::CSR_FRAME_ROWS, CB'(rv));
         end
         if ($urandom_range(0, 4) == 0)
            write_csr(AB'($urandom_range(CSR_SPARE_LO, 15)),
                      CB'($urandom_range(0, 63)));
         tx_burst = ($urandom_range(0, 3) == 0);
         if (phase == 0) squeeze_go = 1'b1;
         nfr = $urandom_range(1, 3);
         for (int f = 0; f < nfr; f++) begin
            shape = $urandom_range(0, 99);
            shape = (phase == 0 || shape < 80) ? 0 : (shape < 92) ? 1 : 2;
            style = $urandom_range(0, 2);
            send_frame(dim_of(CB'(rv)), dim_of(CB'(cv)), shape, style);
         end
      end

      wait_idle();
      repeat (DRAIN) @(posedge clock);
      if (mismatch_cnt == 0 && peak_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
sv/glpf_pkg.sv
sv/glpf_ram.sv
sv/glpf_eval.sv
sv/grid_local_peak_finder_core.sv
test/tb.sv
